### design/pbrt_pkg.sv
// Package: shared types and constants for the picture buffer refcount table.
`default_nettype none
package pbrt_pkg;
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int KEY_W = 48;
  localparam int HDL_W = 16;
  localparam int SZ_W = 24;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int REF_W = 2;
  localparam logic [REF_W-1:0] INIT_REFS = REF_W'(2);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [KEY_W-1:0] WIN_RESET = KEY_W'(500000000);

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] timestamp;
    logic [HDL_W-1:0] payload_handle;
    logic [SZ_W-1:0]  payload_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key_used;
    logic [HDL_W-1:0] out_handle;
    logic [SZ_W-1:0]  out_size;
    logic [CNT_W-1:0] occupancy;
  } out_item_t;

  // Broadcast from sequencer to every cell.
  typedef struct packed {
    logic [KEY_W-1:0] cmp_key;
    logic [KEY_W-1:0] ts;
    logic [KEY_W-1:0] prev;
    logic [KEY_W-1:0] lo;
    logic             wide;
    logic             jumped;
    logic [HDL_W-1:0] handle;
    logic [SZ_W-1:0]  size;
  } cell_bcast_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             win;
    logic             mark;
    logic             last_ref;
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] handle;
    logic [SZ_W-1:0]  size;
  } cell_stat_t;
endpackage
`default_nettype wire

### design/pbrt_cell.sv
// One table entry: key, payload, reference count and scan token stage.
`default_nettype none
module pbrt_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire pbrt_pkg::cell_bcast_t bcast,
  input  wire                      wr_sel,
  input  wire                      dec_sel,
  input  wire                      tok_in,
  output logic                     tok_out,
  output pbrt_pkg::cell_stat_t     stat
);
  logic                          valid_r;
  logic [pbrt_pkg::KEY_W-1:0]    key_r;
  logic [pbrt_pkg::HDL_W-1:0]    handle_r;
  logic [pbrt_pkg::SZ_W-1:0]     size_r;
  logic [pbrt_pkg::REF_W-1:0]    refs_r;
  logic                          tok_r;
  logic                          win;
  logic                          mark;
  logic                          drop;

  always_comb begin
    win = valid_r && (key_r < bcast.ts) && (bcast.wide || (key_r > bcast.lo));
    mark = win || (valid_r && bcast.jumped && (key_r > bcast.prev));
    drop = dec_sel || (tok_r && mark);
    stat.valid = valid_r;
    stat.hit = valid_r && (key_r == bcast.cmp_key);
    stat.win = win;
    stat.mark = mark;
    stat.last_ref = (refs_r <= pbrt_pkg::REF_W'(1));
    stat.key = key_r;
    stat.handle = handle_r;
    stat.size = size_r;
    tok_out = tok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (wr_sel) begin
        valid_r <= 1'b1;
      end else if (drop && refs_r <= pbrt_pkg::REF_W'(1)) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      key_r <= bcast.cmp_key;
      handle_r <= bcast.handle;
      size_r <= bcast.size;
      refs_r <= pbrt_pkg::INIT_REFS;
    end else if (drop) begin
      refs_r <= (refs_r <= pbrt_pkg::REF_W'(1)) ? '0 : refs_r - pbrt_pkg::REF_W'(1);
    end
  end
endmodule
`default_nettype wire

### design/picture_buffer_refcount_table.sv
// Top level: picture buffer refcount table with sequencer and cell chain.
// Usage:
//   in_valid/in_ready carry one request item (write, release, read).
//   out_valid/out_ready carry exactly one result item per request.
//   cfg_we/cfg_idx/cfg_wdata write capacity (index 0) or read window
//   (index 1); write only while the block is idle.
// Sequencing:
//   Release and unknown types: dispatch state, then final state, then out_valid.
//   Write: dispatch, then a probe state that repeats once per key collision;
//   a write rejected as full goes from dispatch straight to the final state.
//   Read: a scan token walks the 16-cell chain, one cell a cycle,
//   dropping a reference of each marked entry and tracking the largest key.
//   One item is in work at a time; in_ready is high only when idle.
// Reset (synchronous, rst_n low): all entries invalid, live count and
//   previous request zero, capacity 16, window 500000000.
// Stall: a finished result waits in the output register until out_ready;
//   a new item may be taken meanwhile, and its result then holds the
//   sequencer in its final state until the output register frees.
`default_nettype none
module picture_buffer_refcount_table (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire pbrt_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output pbrt_pkg::out_item_t  out_item,
  input  wire                  cfg_we,
  input  wire                  cfg_idx,
  input  wire [47:0]           cfg_wdata
);
  typedef enum logic [2:0] {S_IDLE, S_DISP, S_WPROBE, S_SCAN, S_FIN} state_t;

  state_t                          state_r;
  logic [pbrt_pkg::CAP_W-1:0]      cap_r;
  logic [pbrt_pkg::KEY_W-1:0]      win_r;
  logic [pbrt_pkg::CNT_W-1:0]      live_r;
  logic [1:0]                      type_r;
  pbrt_pkg::cell_bcast_t           bc_r;
  logic [pbrt_pkg::IDX_W-1:0]      idx_r;
  logic [1:0]                      st_r;
  logic [pbrt_pkg::KEY_W-1:0]      key_r;
  logic [pbrt_pkg::HDL_W-1:0]      hdl_r;
  logic [pbrt_pkg::SZ_W-1:0]       sz_r;
  logic                            found_r;
  logic                            out_valid_r;
  pbrt_pkg::out_item_t             out_r;

  pbrt_pkg::cell_stat_t            stat [pbrt_pkg::DEPTH];
  logic [pbrt_pkg::DEPTH-1:0]      wr_sel;
  logic [pbrt_pkg::DEPTH-1:0]      dec_sel;
  logic [pbrt_pkg::DEPTH:0]        tok;
  logic [pbrt_pkg::DEPTH-1:0]      hit_vec;
  logic [pbrt_pkg::DEPTH-1:0]      free_oh;
  logic                            any_hit;
  logic                            any_free;
  logic                            hit_last;
  logic                            start_scan;

  genvar g;
  generate
    for (g = 0; g < pbrt_pkg::DEPTH; g++) begin : g_cell
      pbrt_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .bcast   (bc_r),
        .wr_sel  (wr_sel[g]),
        .dec_sel (dec_sel[g]),
        .tok_in  (tok[g]),
        .tok_out (tok[g+1]),
        .stat    (stat[g])
      );
    end
  endgenerate

  assign tok[0] = start_scan;

  always_comb begin
    logic taken;
    taken = 1'b0;
    any_hit = 1'b0;
    hit_last = 1'b0;
    for (int i = 0; i < pbrt_pkg::DEPTH; i++) begin
      hit_vec[i] = stat[i].hit;
      free_oh[i] = !stat[i].valid && !taken;
      taken = taken || !stat[i].valid;
      if (stat[i].hit) begin
        hit_last = hit_last || stat[i].last_ref;
      end
    end
    any_hit = |hit_vec;
    any_free = taken;
    start_scan = (state_r == S_DISP) && (type_r == pbrt_pkg::REQ_READ);
    wr_sel = (state_r == S_WPROBE && !any_hit && any_free) ? free_oh : '0;
    dec_sel = (state_r == S_DISP && type_r == pbrt_pkg::REQ_RELEASE) ? hit_vec : '0;
    in_ready = (state_r == S_IDLE);
    out_valid = out_valid_r;
    out_item = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r <= pbrt_pkg::CAP_RESET;
      win_r <= pbrt_pkg::WIN_RESET;
      live_r <= '0;
      bc_r.prev <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          pbrt_pkg::CFG_CAPACITY: cap_r <= cfg_wdata[pbrt_pkg::CAP_W-1:0];
          pbrt_pkg::CFG_WINDOW:   win_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            type_r <= in_item.req_type;
            bc_r.cmp_key <= in_item.timestamp;
            bc_r.ts <= in_item.timestamp;
            bc_r.lo <= in_item.timestamp - win_r;
            bc_r.wide <= (win_r > in_item.timestamp);
            bc_r.jumped <= (bc_r.prev > in_item.timestamp);
            bc_r.handle <= in_item.payload_handle;
            bc_r.size <= in_item.payload_size;
            st_r <= pbrt_pkg::ST_OK;
            key_r <= '0;
            hdl_r <= '0;
            sz_r <= '0;
            found_r <= 1'b0;
            idx_r <= '0;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (type_r)
            pbrt_pkg::REQ_WRITE: begin
              if (live_r >= pbrt_pkg::CNT_W'(cap_r) ||
                  live_r >= pbrt_pkg::CNT_W'(pbrt_pkg::DEPTH)) begin
                st_r <= pbrt_pkg::ST_FULL;
                state_r <= S_FIN;
              end else begin
                state_r <= S_WPROBE;
              end
            end
            pbrt_pkg::REQ_RELEASE: begin
              if (any_hit) begin
                key_r <= bc_r.cmp_key;
                if (hit_last && live_r != '0) begin
                  live_r <= live_r - pbrt_pkg::CNT_W'(1);
                end
              end else begin
                st_r <= pbrt_pkg::ST_UNKNOWN;
              end
              state_r <= S_FIN;
            end
            pbrt_pkg::REQ_READ: begin
              state_r <= S_SCAN;
            end
            default: begin
              st_r <= pbrt_pkg::ST_NONE;
              state_r <= S_FIN;
            end
          endcase
        end
        S_WPROBE: begin
          if (any_hit) begin
            bc_r.cmp_key <= bc_r.cmp_key + pbrt_pkg::KEY_W'(1);
          end else begin
            if (any_free) begin
              key_r <= bc_r.cmp_key;
              live_r <= live_r + pbrt_pkg::CNT_W'(1);
            end else begin
              st_r <= pbrt_pkg::ST_FULL;
            end
            state_r <= S_FIN;
          end
        end
        S_SCAN: begin
          if (stat[idx_r].win && stat[idx_r].key > key_r) begin
            key_r <= stat[idx_r].key;
            hdl_r <= stat[idx_r].handle;
            sz_r <= stat[idx_r].size;
            found_r <= 1'b1;
          end
          if (stat[idx_r].mark && stat[idx_r].last_ref && live_r != '0) begin
            live_r <= live_r - pbrt_pkg::CNT_W'(1);
          end
          idx_r <= idx_r + pbrt_pkg::IDX_W'(1);
          if (idx_r == pbrt_pkg::IDX_W'(pbrt_pkg::DEPTH - 1)) begin
            bc_r.prev <= bc_r.ts;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_r.status <= (type_r == pbrt_pkg::REQ_READ && !found_r) ?
                            pbrt_pkg::ST_NONE : st_r;
            out_r.key_used <= key_r;
            out_r.out_handle <= hdl_r;
            out_r.out_size <= sz_r;
            out_r.occupancy <= live_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/pbrt_checker.sv
// Port-level checker for the picture buffer refcount table, with bind.
`default_nettype none
module pbrt_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire pbrt_pkg::out_item_t out_item
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_reject_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == pbrt_pkg::ST_FULL ||
                  out_item.status == pbrt_pkg::ST_NONE) |->
    out_item.key_used == '0 && out_item.out_size == '0)
    else $error("failed request returned a key");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.occupancy <= pbrt_pkg::CNT_W'(pbrt_pkg::DEPTH))
    else $error("occupancy beyond table depth");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind picture_buffer_refcount_table pbrt_checker u_pbrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
